// ----- design/rbf_pkg.sv -----
`timescale 1ns / 1ps

package rbf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Fixed field widths of the register and pixel interface
  localparam int FW_W     = 11;
  localparam int FH_W     = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IX_W = 1;
  localparam int CH_W     = 8;
  localparam int DIV_W    = 5;
  localparam int PIX_W    = 3 * DIV_W;
  localparam int LINE_W   = 2 * PIX_W;

  // Derived from the frame limits
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

  localparam logic [CFG_IX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Line store access: one read and one write port per cycle
  typedef struct packed {
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [LINE_W-1:0] wr_data;
  } ram_req_t;

  // Truncating divide by nine: x * 57 >> 9 is exact for x up to 255
  function automatic logic [DIV_W-1:0] div9(input logic [CH_W-1:0] x);
    logic [14:0] prod;
    prod = 15'(x) * 15'd57;
    return prod[13:9];
  endfunction

endpackage

// ----- design/rgb_box_filter_3x3_top.sv -----
`timescale 1ns / 1ps
// Results: the result of a pixel is released by the request one row plus one pixel later
//   and is loaded into the output register as that request leaves stage 1.
// Throughput: one request per cycle while in_stall is low; a column is read when a request
//   issues and written back on a separate port as it leaves stage 1, bypassed when the same column is read then.
// Reset: clears positions, window and pipeline flags; geometry returns to 640 x 480.
//   The line store is not cleared; stale columns only feed edge pixels, which ignore them.

module rgb_box_filter_3x3_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rbf_pkg::CH_W-1:0]    in_red_in,
  input  logic [rbf_pkg::CH_W-1:0]    in_green_in,
  input  logic [rbf_pkg::CH_W-1:0]    in_blue_in,
  input  logic                        in_drain,
  // smoothed results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rbf_pkg::CH_W-1:0]    out_red_out,
  output logic [rbf_pkg::CH_W-1:0]    out_green_out,
  output logic [rbf_pkg::CH_W-1:0]    out_blue_out,
  output logic                        out_frame_end,
  // register writes
  input  logic                        cfg_wr_en,
  input  logic [rbf_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [rbf_pkg::CFG_W-1:0]   cfg_data
);

  // ---------------------------------------------------------------------------
  // Geometry registers, used clamped to 3..MAX
  // ---------------------------------------------------------------------------
  logic [rbf_pkg::FW_W-1:0]   fw_r;
  logic [rbf_pkg::FH_W-1:0]   fh_r;
  logic [rbf_pkg::WEFF_W-1:0] w_eff;
  logic [rbf_pkg::HEFF_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= rbf_pkg::FRAME_WIDTH_RST;
      fh_r <= rbf_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rbf_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_data[rbf_pkg::FW_W-1:0];
        rbf_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_data[rbf_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_r < rbf_pkg::FW_W'(3)) begin
      w_eff = rbf_pkg::WEFF_W'(3);
    end else if (32'(fw_r) > rbf_pkg::MAX_WIDTH) begin
      w_eff = rbf_pkg::WEFF_W'(rbf_pkg::MAX_WIDTH);
    end else begin
      w_eff = rbf_pkg::WEFF_W'(fw_r);
    end
    if (fh_r < rbf_pkg::FH_W'(3)) begin
      h_eff = rbf_pkg::HEFF_W'(3);
    end else if (32'(fh_r) > rbf_pkg::MAX_HEIGHT) begin
      h_eff = rbf_pkg::HEFF_W'(rbf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = rbf_pkg::HEFF_W'(fh_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Issue stage: frame position, classification, line store read
  // ---------------------------------------------------------------------------
  logic [rbf_pkg::COL_W-1:0] col_r, col_nxt;
  logic [rbf_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      flushing;
  logic                      accept;
  logic                      issue;
  logic                      is_interior;
  logic                      is_last;
  logic                      has_result;
  logic [rbf_pkg::PIX_W-1:0] pix_val;

  // stage 1: waiting on the line store read
  logic                      s1_valid_r;
  logic [rbf_pkg::COL_W-1:0] s1_col_r;
  logic [rbf_pkg::PIX_W-1:0] s1_val_r;
  logic                      s1_have_r;
  logic                      s1_int_r;
  logic                      s1_end_r;
  logic                      s1_adv;

  // output register
  logic                      out_valid_r;
  logic [rbf_pkg::CH_W-1:0]  red_r, green_r, blue_r;
  logic                      end_r;

  // Rows past the last one are flush time: any request advances, drain or not
  assign flushing = 32'(row_r) >= 32'(h_eff);

  // Stage 1 leaves when its result has room or it carries no result
  assign s1_adv   = s1_valid_r && (!s1_have_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  // A drain inside the pixel part of the frame changes nothing
  assign issue    = accept && (flushing || !in_drain);

  assign is_interior = (col_r >= rbf_pkg::COL_W'(2)) && (row_r >= rbf_pkg::ROW_W'(2)) &&
                       !flushing;
  // Column 0 of row h+1 releases the bottom right pixel
  assign is_last     = (col_r == '0) && (32'(row_r) == 32'(h_eff) + 1);
  assign has_result  = (row_r >= rbf_pkg::ROW_W'(2)) ||
                       ((row_r == rbf_pkg::ROW_W'(1)) && (col_r != '0));

  assign pix_val = flushing ? '0 : {rbf_pkg::div9(in_blue_in),
                                    rbf_pkg::div9(in_green_in),
                                    rbf_pkg::div9(in_red_in)};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (issue) begin
      if (is_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (32'(col_r) + 1 >= 32'(w_eff)) begin
        col_nxt = '0;
        row_nxt = row_r + rbf_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + rbf_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_wr_en) begin
      // restart the frame so it never mixes two geometries
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (issue) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_col_r  <= col_r;
      s1_val_r  <= pix_val;
      s1_have_r <= has_result;
      s1_int_r  <= is_interior;
      s1_end_r  <= is_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: read at issue, write back {newer, pixel} as stage 1 leaves
  // ---------------------------------------------------------------------------
  rbf_pkg::ram_req_t           ram_req;
  logic [rbf_pkg::LINE_W-1:0]  line_q;
  logic [rbf_pkg::PIX_W-1:0]   older_q;
  logic [rbf_pkg::PIX_W-1:0]   newer_q;

  assign older_q = line_q[rbf_pkg::LINE_W-1:rbf_pkg::PIX_W];
  assign newer_q = line_q[rbf_pkg::PIX_W-1:0];

  always_comb begin
    ram_req.rd_en   = issue;
    ram_req.rd_addr = col_r;
    ram_req.wr_en   = s1_adv;
    ram_req.wr_addr = s1_col_r;
    ram_req.wr_data = {newer_q, s1_val_r};
  end

  rbf_line_ram u_line_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (line_q)
  );

  // ---------------------------------------------------------------------------
  // 3x3 window: rows older / newer / current, shifted left as stage 1 leaves
  // ---------------------------------------------------------------------------
  logic [rbf_pkg::PIX_W-1:0] win_r   [9];
  logic [rbf_pkg::PIX_W-1:0] win_nxt [9];
  logic [rbf_pkg::CH_W-1:0]  res_ch  [3];

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = older_q;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = newer_q;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) begin
        // drop the window after the last result of a frame
        win_r[i] <= s1_end_r ? '0 : win_nxt[i];
      end
    end
  end

  // Center pixel is the old right middle tap, whether it is an edge pixel of
  // this row or the last pixel of the row above. Interior pixels sum all nine.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [8:0] top_sum, mid_sum, bot_sum, all_sum;
      top_sum = 9'(win_nxt[0][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]) +
                9'(win_nxt[1][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]) +
                9'(win_nxt[2][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]);
      mid_sum = 9'(win_nxt[3][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]) +
                9'(win_nxt[4][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]) +
                9'(win_nxt[5][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]);
      bot_sum = 9'(win_nxt[6][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]) +
                9'(win_nxt[7][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]) +
                9'(win_nxt[8][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]);
      all_sum = top_sum + mid_sum + bot_sum;
      if (s1_int_r) begin
        res_ch[k] = all_sum[rbf_pkg::CH_W-1:0];
      end else begin
        res_ch[k] = rbf_pkg::CH_W'(win_r[5][k*rbf_pkg::DIV_W +: rbf_pkg::DIV_W]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, load as a result leaves stage 1
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_have_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_have_r) begin
      red_r   <= res_ch[0];
      green_r <= res_ch[1];
      blue_r  <= res_ch[2];
      end_r   <= s1_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;
  assign out_frame_end = end_r;

endmodule

// ----- design/rbf_line_ram.sv -----
`timescale 1ns / 1ps

// Two previous rows, packed {older, newer} per column; registered read with
// bypass of a write to the same column in the read cycle.
module rbf_line_ram (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbf_pkg::ram_req_t         req,
  output logic [rbf_pkg::LINE_W-1:0] rd_data
);

  logic [rbf_pkg::LINE_W-1:0] mem [rbf_pkg::MAX_WIDTH];
  logic [rbf_pkg::LINE_W-1:0] rd_q_r;
  logic [rbf_pkg::LINE_W-1:0] fwd_data_r;
  logic                       fwd_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (req.rd_en) begin
      fwd_r <= req.wr_en && (req.wr_addr == req.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      fwd_data_r <= req.wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule
